FILE: hw/rtl/hss_pkg.sv
`timescale 1ns / 1ps

package hss_pkg;

    // defaults for the top-level parameters
    localparam int PATTERN_MAX_DEF    = 16;
    localparam int POSITION_WIDTH_DEF = 32;

    // pattern storage is fixed by the two 64-bit pattern registers
    localparam int PAT_BYTES  = 16;
    localparam int PAT_IDX_W  = 4;
    localparam int PAT_BITS   = 8 * PAT_BYTES;
    localparam int LEN_W      = 5;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW,
        REG_PATTERN_HIGH,
        REG_PATTERN_LENGTH
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SHIFT
    } t_state;

    // operand select for the shared byte comparator
    typedef struct packed {
        logic [PAT_IDX_W-1:0] hist_idx;
        logic [PAT_IDX_W-1:0] pat_idx;
    } t_cmp_sel;

endpackage

FILE: hw/rtl/horspool_substring_search.sv
`timescale 1ns / 1ps

// Horspool substring search over a byte stream. Text bytes enter one item at
// a time on the input channel; first_of_text restarts position counting and
// puts the first window end at the pattern length. A byte that does not end
// an alignment window is taken without stalling the input. A byte that ends a
// window is accepted, then compared right to left against the pattern one
// byte at a time, each comparison emitting one result item (position,
// last_of_window) as the output register frees up, then the pattern is
// scanned for the window's last byte to find the bad-character shift. Both
// scans run through the same single byte comparator; the input is stalled
// meanwhile. Output stalls stretch the comparison phase. Positions saturate
// at the maximum of POSITION_WIDTH bits. Pattern bytes and length are written
// over the APB-style port (64-bit data, registers at byte addresses 0, 8 and
// 16); the user must write them only while the block is idle, which the
// block itself does not enforce.

module horspool_substring_search #(
    parameter int PATTERN_MAX    = hss_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_WIDTH = hss_pkg::POSITION_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // text item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_first_of_text,

    // result item channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [POSITION_WIDTH-1:0]       o_position,
    output logic                            o_last_of_window,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [hss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [hss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int LW = hss_pkg::LEN_W;

    logic [63:0]    r_pattern_low;
    logic [63:0]    r_pattern_high;
    logic [LW-1:0]  r_pattern_length;

    hss_pkg::t_reg_idx reg_idx;
    logic              cfg_write;
    logic [LW-1:0]     active_len;

    assign pready    = 1'b1;
    assign reg_idx   = hss_pkg::t_reg_idx'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;

    // register writes, 8-byte stride
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= LW'(1);
        end else if (cfg_write) begin
            unique case (reg_idx)
                hss_pkg::REG_PATTERN_LOW:    r_pattern_low    <= pwdata;
                hss_pkg::REG_PATTERN_HIGH:   r_pattern_high   <= pwdata;
                hss_pkg::REG_PATTERN_LENGTH: r_pattern_length <= pwdata[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_idx)
            hss_pkg::REG_PATTERN_LOW:    prdata = r_pattern_low;
            hss_pkg::REG_PATTERN_HIGH:   prdata = r_pattern_high;
            hss_pkg::REG_PATTERN_LENGTH: prdata = hss_pkg::CFG_DATA_W'(r_pattern_length);
            default:                     prdata = '0;
        endcase
    end

    // length zero acts as one, lengths past the pattern capacity are clipped
    always_comb begin
        priority if (r_pattern_length == '0) begin
            active_len = LW'(1);
        end else if (r_pattern_length > LW'(PATTERN_MAX)) begin
            active_len = LW'(PATTERN_MAX);
        end else begin
            active_len = r_pattern_length;
        end
    end

    hss_seq #(
        .PATTERN_MAX    (PATTERN_MAX),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_text_byte      (i_text_byte),
        .i_first_of_text  (i_first_of_text),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_position       (o_position),
        .o_last_of_window (o_last_of_window),
        .i_pattern        ({r_pattern_high, r_pattern_low}),
        .i_len            (active_len)
    );

endmodule

FILE: hw/rtl/hss_match_unit.sv
`timescale 1ns / 1ps

module hss_match_unit #(
    parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF
) (
    input  logic [hss_pkg::PAT_BITS-1:0] i_pattern,
    input  logic [7:0]                   i_history [PATTERN_MAX],
    input  hss_pkg::t_cmp_sel            i_sel,
    output logic                         o_equal
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0] hist_byte;
    logic [7:0] pat_byte;

    // one history byte against one pattern byte
    assign hist_byte = i_history[i_sel.hist_idx[IDX_W-1:0]];
    assign pat_byte  = i_pattern[i_sel.pat_idx * 8 +: 8];
    assign o_equal   = (hist_byte == pat_byte);

endmodule

FILE: hw/rtl/hss_seq.sv
`timescale 1ns / 1ps

module hss_seq #(
    parameter int PATTERN_MAX    = hss_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_WIDTH = hss_pkg::POSITION_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_first_of_text,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [POSITION_WIDTH-1:0]     o_position,
    output logic                          o_last_of_window,
    input  logic [hss_pkg::PAT_BITS-1:0]  i_pattern,
    input  logic [hss_pkg::LEN_W-1:0]     i_len
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW    = hss_pkg::LEN_W;
    localparam int PW    = hss_pkg::PAT_IDX_W;

    hss_pkg::t_state r_state, n_state;

    logic [7:0]                r_hist [PATTERN_MAX];
    logic [7:0]                n_hist [PATTERN_MAX];
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic [LW-1:0]             r_btwe, n_btwe;
    logic [IDX_W-1:0]          r_i, n_i;
    logic [LW-1:0]             r_d, n_d;
    logic [LW-1:0]             r_len, n_len;
    logic                      r_out_valid, n_out_valid;
    logic [POSITION_WIDTH-1:0] r_out_pos, n_out_pos;
    logic                      r_out_last, n_out_last;

    hss_pkg::t_cmp_sel         cmp_sel;
    logic                      cmp_equal;
    logic [LW-1:0]             eff_btwe;
    logic [POSITION_WIDTH-1:0] i_ext;
    logic [POSITION_WIDTH-1:0] cmp_pos;
    logic                      is_last;

    hss_match_unit #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_pattern (i_pattern),
        .i_history (r_hist),
        .i_sel     (cmp_sel),
        .o_equal   (cmp_equal)
    );

    assign o_in_stall       = (r_state != hss_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_position       = r_out_pos;
    assign o_last_of_window = r_out_last;

    // position of the byte under comparison, floored at zero
    assign i_ext   = POSITION_WIDTH'(r_i);
    assign cmp_pos = (r_pos > i_ext) ? (r_pos - i_ext) : '0;
    assign is_last = !cmp_equal || (LW'(r_i) == LW'(r_len - LW'(1)));
    assign eff_btwe = i_first_of_text ? i_len : r_btwe;

    always_comb begin
        n_state     = r_state;
        n_hist      = r_hist;
        n_pos       = r_pos;
        n_btwe      = r_btwe;
        n_i         = r_i;
        n_d         = r_d;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            hss_pkg::ST_COMPARE: begin
                cmp_sel.hist_idx = PW'(r_i);
                cmp_sel.pat_idx  = PW'(LW'(r_len - LW'(1) - LW'(r_i)));
            end
            hss_pkg::ST_SHIFT: begin
                cmp_sel.hist_idx = '0;
                cmp_sel.pat_idx  = PW'(LW'(r_len - LW'(1) - r_d));
            end
            default: begin
                cmp_sel.hist_idx = PW'(r_i);
                cmp_sel.pat_idx  = PW'(LW'(r_len - LW'(1) - LW'(r_i)));
            end
        endcase

        unique case (r_state)
            hss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_hist[0] = i_text_byte;
                    for (int k = 1; k < PATTERN_MAX; k++) begin
                        n_hist[k] = r_hist[k-1];
                    end
                    if (i_first_of_text) begin
                        n_pos = POSITION_WIDTH'(1);
                    end else if (r_pos != '1) begin
                        n_pos = r_pos + POSITION_WIDTH'(1);
                    end
                    if (eff_btwe > LW'(1)) begin
                        n_btwe = eff_btwe - LW'(1);
                    end else begin
                        n_btwe  = eff_btwe;
                        n_len   = i_len;
                        n_i     = '0;
                        n_state = hss_pkg::ST_COMPARE;
                    end
                end
            end
            hss_pkg::ST_COMPARE: begin
                // one comparison per free output slot, right to left
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = cmp_pos;
                    n_out_last  = is_last;
                    if (is_last) begin
                        n_d     = LW'(1);
                        n_state = hss_pkg::ST_SHIFT;
                    end else begin
                        n_i = r_i + IDX_W'(1);
                    end
                end
            end
            hss_pkg::ST_SHIFT: begin
                // rightmost occurrence of the window's last byte in pattern[0..L-2]
                if (r_d >= r_len) begin
                    n_btwe  = r_len;
                    n_state = hss_pkg::ST_IDLE;
                end else if (cmp_equal) begin
                    n_btwe  = r_d;
                    n_state = hss_pkg::ST_IDLE;
                end else begin
                    n_d = r_d + LW'(1);
                end
            end
            default: begin
                n_state = hss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hss_pkg::ST_IDLE;
            r_pos       <= '0;
            r_btwe      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < PATTERN_MAX; k++) begin
                r_hist[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_btwe      <= n_btwe;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_d        <= n_d;
        r_len      <= n_len;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

endmodule
